@@ rtl/line_view_aligned_normal_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the line view aligned normal core
// Short forms for clocked implication checks with a synchronous reset.
// ----------------------------------------------------------------------------
`ifndef LINE_VIEW_ALIGNED_NORMAL_CORE_ASSERT_SVH
`define LINE_VIEW_ALIGNED_NORMAL_CORE_ASSERT_SVH

// Same-cycle implication, ignored while reset is held.
`define LVAN_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is held.
`define LVAN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Implication that is also checked during reset.
`define LVAN_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ rtl/lvan_pkg.sv @@
// ----------------------------------------------------------------------------
// lvan_pkg
// Shared widths, request types and cross product operand tables.
// ----------------------------------------------------------------------------
package lvan_pkg;

    // Widths of the exact intermediates.
    localparam int COORD_W = 32;
    localparam int TAN_W   = 33;
    localparam int C1_W    = 67;
    localparam int C2_W    = 101;
    localparam int SQ_W    = 2 * C2_W;
    localparam int NORM_W  = 16;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_Z = 2'd2;

    // Operand component for each of the six products of a cross product.
    // Products 2i and 2i+1 are subtracted to give component i.
    localparam int CROSS_A [6] = '{1, 2, 2, 0, 0, 1};
    localparam int CROSS_B [6] = '{2, 1, 0, 2, 1, 0};

    typedef struct packed {
        logic signed [COORD_W-1:0] prev_x;
        logic signed [COORD_W-1:0] prev_y;
        logic signed [COORD_W-1:0] prev_z;
        logic signed [COORD_W-1:0] next_x;
        logic signed [COORD_W-1:0] next_y;
        logic signed [COORD_W-1:0] next_z;
        logic signed [COORD_W-1:0] cur_x;
        logic signed [COORD_W-1:0] cur_y;
        logic signed [COORD_W-1:0] cur_z;
    } lvan_in_t;

    typedef struct packed {
        logic signed [NORM_W-1:0] normal_x;
        logic signed [NORM_W-1:0] normal_y;
        logic signed [NORM_W-1:0] normal_z;
        logic                     degenerate;
    } lvan_out_t;

endpackage

@@ rtl/lvan_dly.sv @@
// ----------------------------------------------------------------------------
// lvan_dly
// Enabled delay line that keeps side data aligned with the main pipeline.
// ----------------------------------------------------------------------------
module lvan_dly #(
    parameter int W = 1,
    parameter int D = 1
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] pipe_reg [D];

    // Shift one place whenever the pipeline advances.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < D; i++) begin
                pipe_reg[i] <= '0;
            end
        end else if (en) begin
            pipe_reg[0] <= d;
            for (int i = 1; i < D; i++) begin
                pipe_reg[i] <= pipe_reg[i-1];
            end
        end
    end

    assign q = pipe_reg[D-1];

endmodule

@@ rtl/lvan_mul.sv @@
// ----------------------------------------------------------------------------
// lvan_mul
// Four-stage signed multiplier built from 32 by 32 bit partial products.
// ----------------------------------------------------------------------------
module lvan_mul #(
    parameter int WA = 33,
    parameter int WB = 33
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic signed [WA-1:0] a,
    input  logic signed [WB-1:0] b,
    output logic signed [WA+WB-1:0] p
);

    localparam int NA = (WA + 31) / 32;
    localparam int NB = (WB + 31) / 32;
    localparam int RW = (NB + 1) * 32;
    localparam int PW = (NA + NB) * 32;
    localparam int OW = WA + WB;

    logic [WA-1:0]    a_abs;
    logic [WB-1:0]    b_abs;
    logic [NA*32-1:0] ma_reg;
    logic [NB*32-1:0] mb_reg;
    logic             neg0_reg;
    logic [63:0]      pp_reg [NA][NB];
    logic             neg1_reg;
    logic [RW-1:0]    row_next [NA];
    logic [RW-1:0]    row_reg [NA];
    logic             neg2_reg;
    logic [PW-1:0]    tot;
    logic [OW-1:0]    tot_trim;
    logic [OW-1:0]    p_reg;

    // Magnitudes; the most negative value maps to its unsigned magnitude.
    assign a_abs = a[WA-1] ? WA'(-a) : WA'(a);
    assign b_abs = b[WB-1] ? WB'(-b) : WB'(b);

    // Row sums of the partial products.
    always_comb begin
        for (int i = 0; i < NA; i++) begin
            row_next[i] = '0;
            for (int j = 0; j < NB; j++) begin
                row_next[i] = row_next[i] + (RW'(pp_reg[i][j]) << (32 * j));
            end
        end
    end

    // Final sum of the rows.
    always_comb begin
        tot = '0;
        for (int i = 0; i < NA; i++) begin
            tot = tot + (PW'(row_reg[i]) << (32 * i));
        end
        tot_trim = tot[OW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ma_reg   <= (NA*32)'(a_abs);
            mb_reg   <= (NB*32)'(b_abs);
            neg0_reg <= a[WA-1] ^ b[WB-1];
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    pp_reg[i][j] <= 64'(ma_reg[32*i +: 32]) * 64'(mb_reg[32*j +: 32]);
                end
            end
            neg1_reg <= neg0_reg;
            row_reg  <= row_next;
            neg2_reg <= neg1_reg;
            p_reg    <= neg2_reg ? (~tot_trim + OW'(1)) : tot_trim;
        end
    end

    assign p = p_reg;

endmodule

@@ rtl/lvan_root.sv @@
// ----------------------------------------------------------------------------
// lvan_root
// Pipelined bit-by-bit search of the largest k with k*k*S <= X*4^(FRAC+1), three lanes.
// ----------------------------------------------------------------------------
module lvan_root #(
    parameter int FRAC = 14,
    parameter int SW   = 202
) (
    input  logic                    aclk,
    input  logic                    en,
    input  logic [2:0][SW-1:0]      x_in,
    input  logic [SW-1:0]           s_in,
    output logic [2:0][FRAC+1:0]    k_out
);

    localparam int NS = FRAC + 2;
    localparam int KW = FRAC + 2;
    localparam int WD = SW + 2 * FRAC + 4;

    // Residual X*4^(FRAC+1) - k*k*S, running product k*S and the partial root per lane.
    logic [WD-1:0] r_reg [NS][3];
    logic [WD-1:0] t_reg [NS][3];
    logic [KW-1:0] k_reg [NS][3];
    logic [SW-1:0] s_reg [NS];

    for (genvar s = 0; s < NS; s++) begin : g_stage
        localparam int J = NS - 1 - s;

        logic [WD-1:0] r_in [3];
        logic [WD-1:0] t_in [3];
        logic [KW-1:0] k_in [3];
        logic [SW-1:0] s_cur;
        logic [WD-1:0] d [3];

        if (s == 0) begin : g_first
            always_comb begin
                s_cur = s_in;
                for (int l = 0; l < 3; l++) begin
                    r_in[l] = WD'(x_in[l]) << (2 * FRAC + 2);
                    t_in[l] = '0;
                    k_in[l] = '0;
                end
            end
        end else begin : g_next
            always_comb begin
                s_cur = s_reg[s-1];
                for (int l = 0; l < 3; l++) begin
                    r_in[l] = r_reg[s-1][l];
                    t_in[l] = t_reg[s-1][l];
                    k_in[l] = k_reg[s-1][l];
                end
            end
        end

        // Cost of setting bit J: (2^(J+1))*k*S + 4^J*S.
        always_comb begin
            for (int l = 0; l < 3; l++) begin
                d[l] = (t_in[l] << (J + 1)) + (WD'(s_cur) << (2 * J));
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                s_reg[s] <= s_cur;
                for (int l = 0; l < 3; l++) begin
                    if (d[l] <= r_in[l]) begin
                        r_reg[s][l] <= r_in[l] - d[l];
                        t_reg[s][l] <= t_in[l] + (WD'(s_cur) << J);
                        k_reg[s][l] <= k_in[l] | (KW'(1) << J);
                    end else begin
                        r_reg[s][l] <= r_in[l];
                        t_reg[s][l] <= t_in[l];
                        k_reg[s][l] <= k_in[l];
                    end
                end
            end
        end
    end

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            k_out[l] = k_reg[NS-1][l];
        end
    end

endmodule

@@ rtl/line_view_aligned_normal_core.sv @@
// ----------------------------------------------------------------------------
// line_view_aligned_normal_core
// View-aligned unit normal for illuminated streamline vertices.
// ----------------------------------------------------------------------------
// Each request on the s_ channel carries the previous, next and current point
// of a vertex; the m_ channel returns the unit normal in signed fixed point
// with NORMAL_FRAC_BITS fraction bits, or a degenerate flag with a zero normal.
// The camera position is set through the cfg_ write port; the user must write
// it only while idle; the block does not enforce this. The pipeline has one input
// stage, two cross products of four multiply stages plus a subtract each,
// four stages of squaring, one sum, one root stage per bit of the root,
// and the output register. One request enters every cycle unless the pipeline holds.
// The whole pipeline advances on one enable; when the receiver holds m_ready
// low with a result waiting, every stage holds and s_ready drops, so nothing
// is lost or repeated. Reset clears the valid bits and the camera to zero.
// ----------------------------------------------------------------------------
`include "line_view_aligned_normal_core_assert.svh"

module line_view_aligned_normal_core #(
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  lvan_pkg::lvan_in_t                s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output lvan_pkg::lvan_out_t               m_data,
    input  logic                              cfg_we,
    input  logic [lvan_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lvan_pkg::COORD_W-1:0]      cfg_data
);

    import lvan_pkg::*;

    localparam int FRAC = NORMAL_FRAC_BITS;
    localparam int KW   = FRAC + 2;
    localparam int VLAT = FRAC + 18;

    logic en;

    logic signed [COORD_W-1:0] cam_reg [3];
    logic signed [TAN_W-1:0]   t_reg [3];
    logic signed [TAN_W-1:0]   v_reg [3];

    logic signed [2*TAN_W-1:0]      p1 [6];
    logic signed [C1_W-1:0]         c1_reg [3];
    logic [3*TAN_W-1:0]             t_pack;
    logic [3*TAN_W-1:0]             td_pack;
    logic signed [TAN_W-1:0]        td [3];
    logic signed [C1_W+TAN_W-1:0]   p2 [6];
    logic signed [C2_W-1:0]         c2_reg [3];
    logic signed [2*C2_W-1:0]       sq [3];
    logic [2:0][SQ_W-1:0]           x_reg;
    logic [SQ_W-1:0]                s_reg;
    logic [SQ_W-1:0]                s_next;

    logic       c1_zero;
    logic       c1_zero_d;
    logic       deg_reg;
    logic       deg_d;
    logic [2:0] sign_d;
    logic       valid_d;
    logic [2:0][KW-1:0] k_root;

    logic [KW:0]               m_round [3];
    logic [KW-1:0]             m_mag [3];
    logic [NORM_W-2:0]         m_sat [3];
    logic signed [NORM_W-1:0]  n_val [3];
    lvan_out_t                 out_next;
    lvan_out_t                 m_data_reg;
    logic                      m_valid_reg;

    // One enable for every stage: advance unless a result is stuck.
    assign en      = m_ready || !m_valid_reg;
    assign s_ready = en;

    // Camera registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                cam_reg[i] <= '0;
            end
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_CAMERA_X: cam_reg[0] <= cfg_data;
                CFG_CAMERA_Y: cam_reg[1] <= cfg_data;
                CFG_CAMERA_Z: cam_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input stage: tangent and view vectors.
    always_ff @(posedge aclk) begin
        if (en) begin
            t_reg[0] <= TAN_W'(s_data.next_x) - TAN_W'(s_data.prev_x);
            t_reg[1] <= TAN_W'(s_data.next_y) - TAN_W'(s_data.prev_y);
            t_reg[2] <= TAN_W'(s_data.next_z) - TAN_W'(s_data.prev_z);
            v_reg[0] <= TAN_W'(cam_reg[0]) - TAN_W'(s_data.cur_x);
            v_reg[1] <= TAN_W'(cam_reg[1]) - TAN_W'(s_data.cur_y);
            v_reg[2] <= TAN_W'(cam_reg[2]) - TAN_W'(s_data.cur_z);
        end
    end

    // First cross product: tangent x view.
    for (genvar i = 0; i < 6; i++) begin : g_c1_mul
        lvan_mul #(.WA(TAN_W), .WB(TAN_W)) u_mul (
            .aclk (aclk),
            .en   (en),
            .a    (t_reg[CROSS_A[i]]),
            .b    (v_reg[CROSS_B[i]]),
            .p    (p1[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                c1_reg[i] <= C1_W'(p1[2*i]) - C1_W'(p1[2*i+1]);
            end
        end
    end

    // Tangent held until the first cross product is ready.
    assign t_pack = {t_reg[2], t_reg[1], t_reg[0]};

    lvan_dly #(.W(3*TAN_W), .D(5)) u_t_dly (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .d       (t_pack),
        .q       (td_pack)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            td[i] = td_pack[TAN_W*i +: TAN_W];
        end
    end

    // Second cross product: c1 x tangent.
    for (genvar i = 0; i < 6; i++) begin : g_c2_mul
        lvan_mul #(.WA(C1_W), .WB(TAN_W)) u_mul (
            .aclk (aclk),
            .en   (en),
            .a    (c1_reg[CROSS_A[i]]),
            .b    (td[CROSS_B[i]]),
            .p    (p2[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                c2_reg[i] <= C2_W'(p2[2*i]) - C2_W'(p2[2*i+1]);
            end
        end
    end

    // A zero first cross product marks the vertex degenerate.
    assign c1_zero = (c1_reg[0] == '0) && (c1_reg[1] == '0) && (c1_reg[2] == '0);

    lvan_dly #(.W(1), .D(9)) u_zero_dly (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .d       (c1_zero),
        .q       (c1_zero_d)
    );

    // Squares of the normal direction components.
    for (genvar i = 0; i < 3; i++) begin : g_sq_mul
        lvan_mul #(.WA(C2_W), .WB(C2_W)) u_mul (
            .aclk (aclk),
            .en   (en),
            .a    (c2_reg[i]),
            .b    (c2_reg[i]),
            .p    (sq[i])
        );
    end

    // Squared length and per-component squares.
    assign s_next = SQ_W'(sq[0]) + SQ_W'(sq[1]) + SQ_W'(sq[2]);

    always_ff @(posedge aclk) begin
        if (en) begin
            s_reg   <= s_next;
            deg_reg <= c1_zero_d || (s_next == '0);
            for (int i = 0; i < 3; i++) begin
                x_reg[i] <= SQ_W'(sq[i]);
            end
        end
    end

    // Root search per component.
    lvan_root #(.FRAC(FRAC), .SW(SQ_W)) u_root (
        .aclk  (aclk),
        .en    (en),
        .x_in  (x_reg),
        .s_in  (s_reg),
        .k_out (k_root)
    );

    lvan_dly #(.W(1), .D(FRAC + 2)) u_deg_dly (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .d       (deg_reg),
        .q       (deg_d)
    );

    lvan_dly #(.W(3), .D(FRAC + 7)) u_sign_dly (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .d       ({c2_reg[2][C2_W-1], c2_reg[1][C2_W-1], c2_reg[0][C2_W-1]}),
        .q       (sign_d)
    );

    lvan_dly #(.W(1), .D(VLAT)) u_valid_dly (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .d       (s_valid && s_ready),
        .q       (valid_d)
    );

    // Round half up from the odd bound, saturate and apply the sign.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            m_round[i] = (KW+1)'(k_root[i]) + (KW+1)'(1);
            m_mag[i]   = m_round[i][KW:1];
            if (32'(m_mag[i]) > 32'd32767) begin
                m_sat[i] = '1;
            end else begin
                m_sat[i] = (NORM_W-1)'(m_mag[i]);
            end
            if (deg_d) begin
                n_val[i] = '0;
            end else if (sign_d[i]) begin
                n_val[i] = -NORM_W'(m_sat[i]);
            end else begin
                n_val[i] = NORM_W'(m_sat[i]);
            end
        end
        out_next.normal_x   = n_val[0];
        out_next.normal_y   = n_val[1];
        out_next.normal_z   = n_val[2];
        out_next.degenerate = deg_d;
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= valid_d;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // A degenerate result carries a zero normal.
    `LVAN_ASSERT_IMPL(a_deg_zero, aclk, aresetn, m_valid && m_data.degenerate,
        m_data.normal_x == 0 && m_data.normal_y == 0 && m_data.normal_z == 0,
        "degenerate result with nonzero normal")

    // A proper result is never the zero vector.
    `LVAN_ASSERT_IMPL(a_nonzero, aclk, aresetn, m_valid && !m_data.degenerate,
        m_data.normal_x != 0 || m_data.normal_y != 0 || m_data.normal_z != 0,
        "normal is zero without the degenerate flag")

    // A waiting result stops the intake.
    `LVAN_ASSERT_IMPL(a_stall_in, aclk, aresetn, m_valid && !m_ready, !s_ready,
        "request taken while a result is stalled")

    // No result in the cycle after a reset edge.
    `LVAN_ASSERT_NEXT(a_reset_out, aclk, 1'b1, !aresetn, !m_valid,
        "result valid right after reset")

endmodule

@@ verif/line_view_aligned_normal_core_test.sv @@
// ----------------------------------------------------------------------------
// line_view_aligned_normal_core_test
// Self-checking testbench for the view-aligned streamline normal core.
// ----------------------------------------------------------------------------
// Vertex requests are sent through the s_ channel. Each request's expected
// normal is worked out in exact wide integer arithmetic and queued. Every
// result on the m_ channel is compared field by field with the oldest
// expectation. The camera is moved between phases, including its extremes.
// Idling on both sides is varied so that stalls land on every pipeline stage.
// ----------------------------------------------------------------------------
module line_view_aligned_normal_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lvan_pkg::*;

    localparam int NFRAC = 14;
    localparam int DRAIN_CYCLES = 19 + NFRAC + 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam logic signed [31:0] C_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] C_MIN = 32'sh80000000;

    typedef logic signed [255:0] wide_t;
    typedef wide_t vec3_t [3];

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    lvan_in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    lvan_out_t m_data;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [COORD_W-1:0] cfg_data = '0;

    // Camera copy that the normal predictor uses.
    logic signed [31:0] cam_pos [3] = '{0, 0, 0};

    lvan_out_t normal_queue [$];
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cycles = 0;
    int fail_count = 0;

    line_view_aligned_normal_core #(.NORMAL_FRAC_BITS(NFRAC)) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    // Exact cross product on wide signed integers.
    function automatic vec3_t cross_wide(vec3_t a, vec3_t b);
        vec3_t r;
        r[0] = a[1] * b[2] - a[2] * b[1];
        r[1] = a[2] * b[0] - a[0] * b[2];
        r[2] = a[0] * b[1] - a[1] * b[0];
        return r;
    endfunction

    // Largest m with (2m-1)^2 * sumsq <= x^2 * 4^(F+1), i.e. |x|/|c2| with F fraction bits, rounded.
    function automatic logic signed [15:0] unit_part(wide_t x, wide_t sumsq);
        wide_t mag, rhs, lhs, kk;
        longint lo, hi, mid;
        logic neg;
        neg = x < 0;
        mag = neg ? -x : x;
        rhs = (mag * mag) <<< (2 * NFRAC + 2);
        lo = 0;
        hi = longint'(1) << NFRAC;
        while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            kk = 2 * mid - 1;
            lhs = kk * kk * sumsq;
            if (lhs <= rhs) lo = mid;
            else hi = mid - 1;
        end
        if (lo > 32767) lo = 32767;
        return neg ? 16'(-lo) : 16'(lo);
    endfunction

    function automatic lvan_out_t predict_normal(lvan_in_t d);
        vec3_t t, v, c1, c2;
        wide_t sumsq;
        lvan_out_t r;
        t[0] = wide_t'(d.next_x) - wide_t'(d.prev_x);
        t[1] = wide_t'(d.next_y) - wide_t'(d.prev_y);
        t[2] = wide_t'(d.next_z) - wide_t'(d.prev_z);
        v[0] = wide_t'(cam_pos[0]) - wide_t'(d.cur_x);
        v[1] = wide_t'(cam_pos[1]) - wide_t'(d.cur_y);
        v[2] = wide_t'(cam_pos[2]) - wide_t'(d.cur_z);
        c1 = cross_wide(t, v);
        c2 = cross_wide(c1, t);
        sumsq = c2[0] * c2[0] + c2[1] * c2[1] + c2[2] * c2[2];
        r = '0;
        if ((c1[0] == 0 && c1[1] == 0 && c1[2] == 0) || sumsq == 0) begin
            r.degenerate = 1'b1;
        end else begin
            r.normal_x = unit_part(c2[0], sumsq);
            r.normal_y = unit_part(c2[1], sumsq);
            r.normal_z = unit_part(c2[2], sumsq);
        end
        return r;
    endfunction

    // Send one vertex request; valid stays high between back-to-back requests.
    task automatic send_vertex(lvan_in_t d);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= d;
        forever begin
            @(posedge aclk);
            if (s_ready) break;
        end
        normal_queue.push_back(predict_normal(d));
    endtask

    // Hold off the sender until the pipeline is empty.
    task automatic drain_pipeline();
        s_valid <= 1'b0;
        while (normal_queue.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Write the camera, plus a write to the unused index that must be ignored.
    task automatic set_camera(logic signed [31:0] x, logic signed [31:0] y,
                              logic signed [31:0] z);
        logic [CFG_IDX_W-1:0] idx [4];
        logic [31:0] val [4];
        idx = '{CFG_CAMERA_X, CFG_CAMERA_Y, CFG_CAMERA_Z, CFG_UNUSED};
        val = '{x, y, z, $urandom};
        drain_pipeline();
        for (int i = 0; i < 4; i++) begin
            cfg_we <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= val[i];
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
        cam_pos = '{x, y, z};
        @(posedge aclk);
    endtask

    function automatic lvan_in_t make_vertex(int px, int py, int pz, int nx, int ny,
                                             int nz, int cx, int cy, int cz);
        lvan_in_t d;
        d = '{px, py, pz, nx, ny, nz, cx, cy, cz};
        return d;
    endfunction

    function automatic int pick_extreme();
        case ($urandom_range(4))
            0: return C_MAX;
            1: return C_MIN;
            2: return 0;
            3: return -1;
            default: return 1;
        endcase
    endfunction

    function automatic lvan_in_t random_vertex();
        lvan_in_t d;
        int sel, k, vx, vy, vz;
        sel = $urandom_range(99);
        if (sel < 60) begin
            // Well-formed streamline segment around a random current point.
            d.cur_x = $urandom; d.cur_y = $urandom; d.cur_z = $urandom;
            d.prev_x = d.cur_x - ($signed($urandom_range(200000)) - 100000);
            d.prev_y = d.cur_y - ($signed($urandom_range(200000)) - 100000);
            d.prev_z = d.cur_z - ($signed($urandom_range(200000)) - 100000);
            d.next_x = d.cur_x + ($signed($urandom_range(200000)) - 100000);
            d.next_y = d.cur_y + ($signed($urandom_range(200000)) - 100000);
            d.next_z = d.cur_z + ($signed($urandom_range(200000)) - 100000);
        end else if (sel < 80) begin
            d = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom};
        end else if (sel < 90) begin
            // Tangent parallel to the view direction.
            vx = $signed($urandom_range(2000)) - 1000;
            vy = $signed($urandom_range(2000)) - 1000;
            vz = $signed($urandom_range(2000)) - 1000;
            k = $signed($urandom_range(20)) - 10;
            d.cur_x = cam_pos[0] - vx; d.cur_y = cam_pos[1] - vy; d.cur_z = cam_pos[2] - vz;
            d.prev_x = $urandom; d.prev_y = $urandom; d.prev_z = $urandom;
            d.next_x = d.prev_x + k * vx;
            d.next_y = d.prev_y + k * vy;
            d.next_z = d.prev_z + k * vz;
        end else begin
            d = {pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
                 pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
                 pick_extreme()};
        end
        return d;
    endfunction

    // Receiver stalls at random.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge aclk) begin
        lvan_out_t exp_n;
        if (aresetn && m_valid && m_ready) begin
            if (normal_queue.size() == 0) begin
                $error("result with no request outstanding: %h", m_data);
                fail_count++;
            end else begin
                exp_n = normal_queue.pop_front();
                if (m_data.normal_x !== exp_n.normal_x) begin
                    $error("normal_x expected %0d actual %0d", exp_n.normal_x, m_data.normal_x);
                    fail_count++;
                end
                if (m_data.normal_y !== exp_n.normal_y) begin
                    $error("normal_y expected %0d actual %0d", exp_n.normal_y, m_data.normal_y);
                    fail_count++;
                end
                if (m_data.normal_z !== exp_n.normal_z) begin
                    $error("normal_z expected %0d actual %0d", exp_n.normal_z, m_data.normal_z);
                    fail_count++;
                end
                if (m_data.degenerate !== exp_n.degenerate) begin
                    $error("degenerate expected %0b actual %0b",
                           exp_n.degenerate, m_data.degenerate);
                    fail_count++;
                end
            end
        end
    end

    // Run limit.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Camera at its reset value of zero.
    task automatic test_reset_camera();
        send_vertex(make_vertex(0, 0, 0, 65536, 0, 0, 0, 65536, 0));
        send_vertex(make_vertex(0, 0, 0, 0, 0, 65536, 65536, 0, 0));
        send_vertex(make_vertex(5, 5, 5, 5, 5, 5, 1, 2, 3));
    endtask

    // Directed corners: degenerate cases and field extremes.
    task automatic test_directed();
        set_camera(0, 0, 65536 * 10);
        // Zero view: current point at the camera.
        send_vertex(make_vertex(0, 0, 0, 65536, 0, 0, 0, 0, 65536 * 10));
        // Tangent parallel to the view.
        send_vertex(make_vertex(0, 0, 0, 0, 0, 65536, 0, 0, 0));
        send_vertex(make_vertex(0, 0, 0, 65536, 65536, 0, 0, 0, 0));
        send_vertex(make_vertex(3, -7, 11, -5, 9, 2, 100, -200, 300));
        send_vertex(make_vertex(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MIN, 0, C_MAX));
        send_vertex(make_vertex(C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MAX, C_MIN));
        set_camera(C_MAX, C_MIN, C_MAX);
        send_vertex(make_vertex(C_MIN, 0, 0, C_MAX, 0, 0, C_MIN, C_MAX, C_MIN));
        send_vertex(make_vertex(C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN));
        send_vertex(make_vertex(-1, -1, -1, 1, 0, 1, C_MAX, C_MIN, C_MAX));
        set_camera(C_MIN, C_MAX, C_MIN);
        send_vertex(make_vertex(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, C_MAX, C_MIN, C_MAX));
        send_vertex(make_vertex(0, 0, 0, 1, 0, 0, 0, 0, 0));
        send_vertex(make_vertex(0, 1, 0, 0, 0, 1, -1, -1, -1));
    endtask

    // Random vertices under one idling pattern and a fresh camera.
    task automatic test_random_phase(int s_pct, int r_pct, int count);
        set_camera($urandom, $urandom, $urandom);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int i = 0; i < count; i++) begin
            if (i == count / 2) drain_pipeline();
            send_vertex(random_vertex());
        end
        s_valid <= 1'b0;
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_camera();
        test_directed();
        test_random_phase(24, 48, 520);
        test_random_phase(48, 24, 520);
        test_random_phase(0, 0, 510);
        s_valid <= 1'b0;
        while (normal_queue.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
